/* rtl/hbmrb_pkg.sv */
// ----------------------------------------------------------------------------
// hbmrb_pkg: shared types and constants of the H-bridge ramp/brake controller
// Request payloads, configuration and state records, mode and pattern codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hbmrb_pkg;

  // Start-up delay in ticks and control step spacing (a step every
  // STEP_DIVIDE+1 ticks).
  localparam logic [15:0] STARTUP_TICKS = 16'd500;
  localparam logic [3:0]  STEP_DIVIDE   = 4'd10;
  localparam logic [9:0]  BRAKE_STEP    = 10'd5;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_CURRENT_LIMIT    = 3'd0;
  localparam logic [2:0] REG_OVP_SET_LEVEL    = 3'd1;
  localparam logic [2:0] REG_OVP_CLEAR_LEVEL  = 3'd2;
  localparam logic [2:0] REG_DUTY_LIMIT       = 3'd3;
  localparam logic [2:0] REG_BRAKE_START_DUTY = 3'd4;
  localparam logic [2:0] REG_RAMP_INCREMENT   = 3'd5;
  localparam logic [2:0] REG_TEST_ON_TIME     = 3'd6;
  localparam logic [2:0] REG_TEST_OFF_TIME    = 3'd7;

  // Bridge drive patterns.
  localparam logic [2:0] PAT_OFF   = 3'd0;
  localparam logic [2:0] PAT_LOW   = 3'd1;
  localparam logic [2:0] PAT_BRAKE = 3'd2;
  localparam logic [2:0] PAT_UP    = 3'd3;
  localparam logic [2:0] PAT_DOWN  = 3'd4;

  // Reported mode codes.
  localparam logic [2:0] CODE_COAST = 3'd0;
  localparam logic [2:0] CODE_STOP  = 3'd1;
  localparam logic [2:0] CODE_BRAKE = 3'd2;
  localparam logic [2:0] CODE_UP    = 3'd3;
  localparam logic [2:0] CODE_DOWN  = 3'd4;
  localparam logic [2:0] CODE_TSW   = 3'd5;
  localparam logic [2:0] CODE_TUP   = 3'd6;
  localparam logic [2:0] CODE_TDOWN = 3'd7;

  // Motor state machine, one-hot.
  typedef enum logic [7:0] {
    MODE_COAST = 8'b0000_0001,
    MODE_STOP  = 8'b0000_0010,
    MODE_BRAKE = 8'b0000_0100,
    MODE_UP    = 8'b0000_1000,
    MODE_DOWN  = 8'b0001_0000,
    MODE_TSW   = 8'b0010_0000,
    MODE_TUP   = 8'b0100_0000,
    MODE_TDOWN = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic        down_pin;
    logic        up_pin;
    logic        test_pin;
    logic [11:0] supply_voltage;
    logic [11:0] motor_amps;
  } in_t;

  typedef struct packed {
    logic [9:0] pwm_duty;
    logic [2:0] drive_pattern;
    logic [2:0] motor_mode;
    logic       overvoltage_alarm;
  } out_t;

  typedef struct packed {
    logic [11:0] current_limit;
    logic [11:0] ovp_set_level;
    logic [11:0] ovp_clear_level;
    logic [9:0]  duty_limit;
    logic [9:0]  brake_start_duty;
    logic [7:0]  ramp_increment;
    logic [15:0] test_on_time;
    logic [15:0] test_off_time;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [9:0]  duty;
    logic        test_dir;
    logic [15:0] ms_cnt;
    logic        ms_done;
    logic [3:0]  div;
    logic        pending;
    logic        started;
    logic        alarm;
    logic [2:0]  last_pattern;
  } st_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_COAST: c = CODE_COAST;
      MODE_STOP:  c = CODE_STOP;
      MODE_BRAKE: c = CODE_BRAKE;
      MODE_UP:    c = CODE_UP;
      MODE_DOWN:  c = CODE_DOWN;
      MODE_TSW:   c = CODE_TSW;
      MODE_TUP:   c = CODE_TUP;
      MODE_TDOWN: c = CODE_TDOWN;
      default:    c = CODE_BRAKE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/hbmrb_step.sv */
// ----------------------------------------------------------------------------
// hbmrb_step: one-tick update of the motor controller
// Timer, step divider, alarm hysteresis, overcurrent coast and the mode FSM.
// ----------------------------------------------------------------------------
`default_nettype none

module hbmrb_step (
  input  hbmrb_pkg::in_t  tick,
  input  hbmrb_pkg::cfg_t cfg,
  input  hbmrb_pkg::st_t  st,
  output hbmrb_pkg::st_t  st_nxt,
  output hbmrb_pkg::out_t res
);

  always_comb begin
    hbmrb_pkg::st_t nx;
    logic           dir_up;
    logic           dir_down;
    logic           test_on;
    logic [10:0]    ramp_sum;
    logic [9:0]     ramp_duty;
    logic [2:0]     pattern;

    nx = st;

    // Key decode: pins are active low, a direction needs its key alone.
    dir_down = tick.test_pin & tick.up_pin & ~tick.down_pin;
    dir_up   = tick.test_pin & ~tick.up_pin & tick.down_pin;
    test_on  = ~tick.test_pin;

    ramp_sum  = {1'b0, st.duty} + {3'b000, cfg.ramp_increment};
    ramp_duty = (ramp_sum > {1'b0, cfg.duty_limit}) ? cfg.duty_limit : ramp_sum[9:0];

    nx.ms_cnt = st.ms_cnt - 16'd1;
    if (nx.ms_cnt == 16'd0) begin
      nx.ms_done = 1'b1;
    end

    if (st.div >= hbmrb_pkg::STEP_DIVIDE) begin
      nx.div     = 4'd0;
      nx.pending = 1'b1;
    end else begin
      nx.div = st.div + 4'd1;
    end

    if (nx.ms_done) begin
      nx.started = 1'b1;
    end

    if (nx.started) begin
      if (tick.supply_voltage >= cfg.ovp_set_level) begin
        nx.alarm = 1'b1;
      end else if (tick.supply_voltage <= cfg.ovp_clear_level) begin
        nx.alarm = 1'b0;
      end

      if (tick.motor_amps > cfg.current_limit) begin
        nx.mode = hbmrb_pkg::MODE_COAST;
      end

      if (nx.pending) begin
        nx.pending = 1'b0;
        case (nx.mode)
          hbmrb_pkg::MODE_COAST: begin
            nx.duty = 10'd0;
          end
          hbmrb_pkg::MODE_BRAKE: begin
            if (nx.duty < hbmrb_pkg::BRAKE_STEP) begin
              nx.duty = 10'd0;
              nx.mode = hbmrb_pkg::MODE_STOP;
            end else begin
              nx.duty = nx.duty - hbmrb_pkg::BRAKE_STEP;
            end
          end
          hbmrb_pkg::MODE_STOP: begin
            if (!test_on) begin
              nx.test_dir = 1'b0;
            end
            if (test_on && nx.ms_done) begin
              nx.mode = hbmrb_pkg::MODE_TSW;
            end else if (dir_down) begin
              nx.mode = hbmrb_pkg::MODE_DOWN;
            end else if (dir_up) begin
              nx.mode = hbmrb_pkg::MODE_UP;
            end
          end
          hbmrb_pkg::MODE_TSW: begin
            nx.ms_cnt  = cfg.test_on_time;
            nx.ms_done = 1'b0;
            nx.mode    = nx.test_dir ? hbmrb_pkg::MODE_TUP : hbmrb_pkg::MODE_TDOWN;
            nx.test_dir = ~nx.test_dir;
          end
          hbmrb_pkg::MODE_TUP, hbmrb_pkg::MODE_TDOWN: begin
            if (!test_on || nx.ms_done) begin
              nx.ms_cnt  = cfg.test_off_time;
              nx.ms_done = 1'b0;
              nx.duty    = cfg.brake_start_duty;
              nx.mode    = hbmrb_pkg::MODE_BRAKE;
            end else begin
              nx.duty = ramp_duty;
            end
          end
          hbmrb_pkg::MODE_UP: begin
            if (!dir_up) begin
              nx.duty = cfg.brake_start_duty;
              nx.mode = hbmrb_pkg::MODE_BRAKE;
            end else begin
              nx.duty = ramp_duty;
            end
          end
          hbmrb_pkg::MODE_DOWN: begin
            if (!dir_down) begin
              nx.duty = cfg.brake_start_duty;
              nx.mode = hbmrb_pkg::MODE_BRAKE;
            end else begin
              nx.duty = ramp_duty;
            end
          end
          default: begin
            nx.mode = hbmrb_pkg::MODE_BRAKE;
          end
        endcase
      end
    end

    case (nx.mode)
      hbmrb_pkg::MODE_COAST: pattern = hbmrb_pkg::PAT_OFF;
      hbmrb_pkg::MODE_STOP:  pattern = hbmrb_pkg::PAT_LOW;
      hbmrb_pkg::MODE_BRAKE: pattern = hbmrb_pkg::PAT_BRAKE;
      hbmrb_pkg::MODE_UP, hbmrb_pkg::MODE_TUP: pattern = hbmrb_pkg::PAT_UP;
      hbmrb_pkg::MODE_DOWN, hbmrb_pkg::MODE_TDOWN: pattern = hbmrb_pkg::PAT_DOWN;
      default: pattern = st.last_pattern;
    endcase
    nx.last_pattern = pattern;

    st_nxt                = nx;
    res.pwm_duty          = nx.duty;
    res.drive_pattern     = pattern;
    res.motor_mode        = hbmrb_pkg::mode_code(nx.mode);
    res.overvoltage_alarm = nx.alarm;
  end

endmodule

`default_nettype wire

/* rtl/hbridge_motor_ramp_brake_control.sv */
// ----------------------------------------------------------------------------
// hbridge_motor_ramp_brake_control: H-bridge motor ramp and brake controller
// One request per 1 ms tick; one result per tick with duty, pattern, mode
// and the overvoltage alarm. Settings come through an APB-style port.
// ----------------------------------------------------------------------------
// Pipeline: the input register takes a request when it is accepted, and the
// tick update is written into the result register when the input register
// advances. Throughput: one request per cycle while results are taken; the tick
// state is updated in a single pass of compares and small adds between the
// input and result registers. Reset (synchronous, rst_n low) restores the
// settings to their defaults, the start-up timer to 500 ticks, the mode to
// brake and empties the pipeline.
`default_nettype none

module hbridge_motor_ramp_brake_control (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  hbmrb_pkg::in_t         in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output hbmrb_pkg::out_t        out_data,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [4:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  hbmrb_pkg::cfg_t cfg_r;
  hbmrb_pkg::st_t  st_r;
  hbmrb_pkg::st_t  st_nxt;
  hbmrb_pkg::in_t  in_r;
  hbmrb_pkg::out_t res_nxt;
  hbmrb_pkg::out_t out_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            s1_adv;
  logic            cfg_wr;
  logic [2:0]      cfg_idx;

  // The input register moves on whenever the result register is free or
  // its result is being taken in this cycle, so requests stream at full rate.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration port: no wait states; register i sits at byte address 4*i.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_limit    <= 12'd0;
      cfg_r.ovp_set_level    <= 12'd3470;
      cfg_r.ovp_clear_level  <= 12'd3465;
      cfg_r.duty_limit       <= 10'd750;
      cfg_r.brake_start_duty <= 10'd400;
      cfg_r.ramp_increment   <= 8'd10;
      cfg_r.test_on_time     <= 16'd2000;
      cfg_r.test_off_time    <= 16'd3000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hbmrb_pkg::REG_CURRENT_LIMIT:    cfg_r.current_limit    <= pwdata[11:0];
        hbmrb_pkg::REG_OVP_SET_LEVEL:    cfg_r.ovp_set_level    <= pwdata[11:0];
        hbmrb_pkg::REG_OVP_CLEAR_LEVEL:  cfg_r.ovp_clear_level  <= pwdata[11:0];
        hbmrb_pkg::REG_DUTY_LIMIT:       cfg_r.duty_limit       <= pwdata[9:0];
        hbmrb_pkg::REG_BRAKE_START_DUTY: cfg_r.brake_start_duty <= pwdata[9:0];
        hbmrb_pkg::REG_RAMP_INCREMENT:   cfg_r.ramp_increment   <= pwdata[7:0];
        hbmrb_pkg::REG_TEST_ON_TIME:     cfg_r.test_on_time     <= pwdata[15:0];
        hbmrb_pkg::REG_TEST_OFF_TIME:    cfg_r.test_off_time    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hbmrb_pkg::REG_CURRENT_LIMIT:    prdata = {20'd0, cfg_r.current_limit};
      hbmrb_pkg::REG_OVP_SET_LEVEL:    prdata = {20'd0, cfg_r.ovp_set_level};
      hbmrb_pkg::REG_OVP_CLEAR_LEVEL:  prdata = {20'd0, cfg_r.ovp_clear_level};
      hbmrb_pkg::REG_DUTY_LIMIT:       prdata = {22'd0, cfg_r.duty_limit};
      hbmrb_pkg::REG_BRAKE_START_DUTY: prdata = {22'd0, cfg_r.brake_start_duty};
      hbmrb_pkg::REG_RAMP_INCREMENT:   prdata = {24'd0, cfg_r.ramp_increment};
      hbmrb_pkg::REG_TEST_ON_TIME:     prdata = {16'd0, cfg_r.test_on_time};
      hbmrb_pkg::REG_TEST_OFF_TIME:    prdata = {16'd0, cfg_r.test_off_time};
      default:                         prdata = 32'd0;
    endcase
  end

  // The tick update itself: all of the controller's state advances once per
  // request, as the request leaves the input register.
  hbmrb_step u_step (
    .tick   (in_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= hbmrb_pkg::MODE_BRAKE;
      st_r.duty         <= 10'd0;
      st_r.test_dir     <= 1'b0;
      st_r.ms_cnt       <= hbmrb_pkg::STARTUP_TICKS;
      st_r.ms_done      <= 1'b0;
      st_r.div          <= 4'd0;
      st_r.pending      <= 1'b0;
      st_r.started      <= 1'b0;
      st_r.alarm        <= 1'b0;
      st_r.last_pattern <= hbmrb_pkg::PAT_BRAKE;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Before start-up ends the motor is held in brake with zero duty.
  a_startup_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.started |-> (st_r.mode == hbmrb_pkg::MODE_BRAKE && st_r.duty == 10'd0))
    else $error("motor state moved before start-up ended");

  // Coast after overcurrent is left only through reset.
  a_coast_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == hbmrb_pkg::MODE_COAST |=> st_r.mode == hbmrb_pkg::MODE_COAST)
    else $error("coast mode was left without reset");

  // Once started, the controller stays started.
  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.started |=> st_r.started)
    else $error("started flag dropped");

  // A stalled result blocks a waiting request in the input register.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s1_valid_r) |-> !in_ready)
    else $error("input taken while the pipeline is full");

  // The state only changes when a request passes into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("controller state changed without a tick");

endmodule

`default_nettype wire
